// File: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the CRC-32 engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent holds in a cycle, so the consequent holds in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent holds in a cycle, so the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/crc_pkg.sv
// Package with the types, constants and step functions of the CRC-32 engine.
`default_nettype none

package crc_pkg;

    localparam logic [31:0] CRC_ONES = 32'hffffffff;
    localparam logic [31:0] CRC_POLY = 32'hedb88320;
    localparam logic [31:0] CRC_INV  = 32'h5b358fd3;
    localparam logic [31:0] CRC_ONE  = 32'h80000000;
    localparam logic [31:0] CRC_X8   = 32'h00800000;

    localparam int MUL_STEPS = 32;
    localparam int MUL_CNT_W = 5;

    typedef enum logic [2:0] {
        CMD_INIT   = 3'd0,
        CMD_UPDATE = 3'd1,
        CMD_UNDO   = 3'd2,
        CMD_LOAD   = 3'd3,
        CMD_APPEND = 3'd4,
        CMD_ADJUST = 3'd5
    } t_cmd;

    typedef struct packed {
        logic        start;
        logic [31:0] a;
        logic [31:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] p;
    } t_mul_rsp;

    function automatic logic [31:0] crc_shift1(input logic [31:0] c);
        crc_shift1 = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    endfunction

    function automatic logic [31:0] crc_unshift1(input logic [31:0] c);
        crc_unshift1 = c[31] ? (((c ^ CRC_POLY) << 1) | 32'd1) : (c << 1);
    endfunction

endpackage

`default_nettype wire

// File: hdl/crc32_engine_with_undo_combine_force_top.sv
// Top level of the CRC-32 engine with undo, combine and force operations.
`default_nettype none
`include "assert_macros.svh"

// Reflected CRC-32 engine (polynomial 0xEDB88320, init and final XOR all ones)
// that keeps one raw running CRC. Init, update, undo, load and the unused
// command codes compute the new CRC combinationally, and the result appears
// in the output register on the next cycle. Append and adjust run on one
// shared bit-serial polynomial multiplier. Adjust needs one product. Append
// needs one product for every length bit up to the highest set one, one more
// for every set bit, and a final one. The block takes no new transaction while
// such a command is in progress or while the previous result is still held
// and not being taken.
module crc32_engine_with_undo_combine_force_top
    import crc_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [31:0] i_value_a,
    input  wire logic [31:0] i_value_b,
    input  wire logic [15:0] i_second_length,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [31:0] o_result_value
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_APP_CHK,
        S_MULR_WAIT,
        S_SQR_WAIT,
        S_FIN_WAIT,
        S_ADJ_WAIT
    } t_state;

    t_state                 r_state, n_state;
    logic [31:0]            r_crc, n_crc;
    logic                   r_out_valid, n_out_valid;
    logic [31:0]            r_result, n_result;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic [31:0]            r_r, n_r;
    logic [31:0]            r_base, n_base;
    logic [31:0]            r_va, n_va;
    logic [31:0]            r_vb, n_vb;
    logic                   r_mul_start, n_mul_start;
    logic [31:0]            r_mul_a, n_mul_a;
    logic [31:0]            r_mul_b, n_mul_b;

    logic        w_in_fire;
    logic        w_long;
    logic [31:0] w_crc_fwd;
    logic [31:0] w_crc_bwd;
    t_mul_req    w_mul_req;
    t_mul_rsp    w_mul_rsp;

    crc_byte u_byte (
        .i_crc       (r_crc),
        .i_data_byte (i_data_byte),
        .o_crc_fwd   (w_crc_fwd),
        .o_crc_bwd   (w_crc_bwd)
    );

    assign w_mul_req.start = r_mul_start;
    assign w_mul_req.a     = r_mul_a;
    assign w_mul_req.b     = r_mul_b;

    crc_gfmul u_gfmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_long     = (i_cmd == CMD_APPEND) || (i_cmd == CMD_ADJUST);

    always_comb begin
        n_state     = r_state;
        n_crc       = r_crc;
        n_out_valid = r_out_valid;
        n_result    = r_result;
        n_len       = r_len;
        n_r         = r_r;
        n_base      = r_base;
        n_va        = r_va;
        n_vb        = r_vb;
        n_mul_start = 1'b0;
        n_mul_a     = r_mul_a;
        n_mul_b     = r_mul_b;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_va = i_value_a;
                    n_vb = i_value_b;
                    case (t_cmd'(i_cmd))
                        CMD_INIT:   n_crc = CRC_ONES;
                        CMD_UPDATE: n_crc = w_crc_fwd;
                        CMD_UNDO:   n_crc = w_crc_bwd;
                        CMD_LOAD:   n_crc = i_value_a ^ CRC_ONES;
                        CMD_APPEND: begin
                            n_len   = LENGTH_BITS'(i_second_length);
                            n_r     = CRC_ONE;
                            n_base  = CRC_X8;
                            n_state = S_APP_CHK;
                        end
                        CMD_ADJUST: begin
                            n_mul_start = 1'b1;
                            n_mul_a     = i_value_b ^ CRC_ONES;
                            n_mul_b     = CRC_INV;
                            n_state     = S_ADJ_WAIT;
                        end
                        default: ;
                    endcase
                    if (!w_long) begin
                        n_out_valid = 1'b1;
                        n_result    = n_crc ^ CRC_ONES;
                    end
                end
            end
            S_APP_CHK: begin
                n_mul_start = 1'b1;
                if (r_len == '0) begin
                    n_mul_a = r_r;
                    n_mul_b = r_va;
                    n_state = S_FIN_WAIT;
                end else if (r_len[0]) begin
                    n_mul_a = r_r;
                    n_mul_b = r_base;
                    n_state = S_MULR_WAIT;
                end else begin
                    n_mul_a = r_base;
                    n_mul_b = r_base;
                    n_state = S_SQR_WAIT;
                end
            end
            S_MULR_WAIT: begin
                if (w_mul_rsp.done) begin
                    n_r         = w_mul_rsp.p;
                    n_mul_start = 1'b1;
                    n_mul_a     = r_base;
                    n_mul_b     = r_base;
                    n_state     = S_SQR_WAIT;
                end
            end
            S_SQR_WAIT: begin
                if (w_mul_rsp.done) begin
                    n_base  = w_mul_rsp.p;
                    n_len   = r_len >> 1;
                    n_state = S_APP_CHK;
                end
            end
            S_FIN_WAIT: begin
                if (w_mul_rsp.done) begin
                    n_result    = w_mul_rsp.p ^ r_vb;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_ADJ_WAIT: begin
                if (w_mul_rsp.done) begin
                    n_result    = w_mul_rsp.p ^ r_va ^ CRC_ONES;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_crc       <= CRC_ONES;
            r_out_valid <= 1'b0;
            r_mul_start <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
            r_mul_start <= n_mul_start;
        end
        r_result <= n_result;
        r_len    <= n_len;
        r_r      <= n_r;
        r_base   <= n_base;
        r_va     <= n_va;
        r_vb     <= n_vb;
        r_mul_a  <= n_mul_a;
        r_mul_b  <= n_mul_b;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_result;

    `ASSERT_SAME(a_ready_mul_idle, i_clk, i_rst_n, o_in_ready, !w_mul_rsp.busy, "ready while the multiplier is busy")
    `ASSERT_SAME(a_done_not_idle, i_clk, i_rst_n, w_mul_rsp.done, r_state != S_IDLE, "product arrived while idle")
    `ASSERT_NEXT(a_long_blocks, i_clk, i_rst_n, w_in_fire && w_long, !o_out_valid && !o_in_ready, "long command did not block")
    `ASSERT_NEXT(a_init_zero, i_clk, i_rst_n, w_in_fire && (i_cmd == CMD_INIT), o_out_valid && (o_result_value == 32'd0), "init result is not zero")

endmodule

`default_nettype wire

// File: hdl/crc_byte.sv
// Forward and reverse folding of one message byte into the raw CRC.
`default_nettype none

module crc_byte
    import crc_pkg::*;
(
    input  wire logic [31:0] i_crc,
    input  wire logic [7:0]  i_data_byte,
    output logic      [31:0] o_crc_fwd,
    output logic      [31:0] o_crc_bwd
);

    always_comb begin
        logic [31:0] v_fwd;
        logic [31:0] v_bwd;
        v_fwd = i_crc ^ {24'd0, i_data_byte};
        v_bwd = i_crc;
        for (int k = 0; k < 8; k++) begin
            v_fwd = crc_shift1(v_fwd);
            v_bwd = crc_unshift1(v_bwd);
        end
        o_crc_fwd = v_fwd;
        o_crc_bwd = v_bwd ^ {24'd0, i_data_byte};
    end

endmodule

`default_nettype wire

// File: hdl/crc_gfmul.sv
// Bit-serial multiplier of two residues modulo the CRC-32 polynomial.
`default_nettype none

module crc_gfmul
    import crc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    output t_mul_rsp      o_rsp
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [MUL_CNT_W-1:0] r_cnt, n_cnt;
    logic [31:0]          r_a, n_a;
    logic [31:0]          r_b, n_b;
    logic [31:0]          r_p, n_p;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_p    = r_p;
        if (i_req.start) begin
            n_a    = i_req.a;
            n_b    = i_req.b;
            n_p    = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_a[31]) begin
                n_p = r_p ^ r_b;
            end
            n_b   = crc_shift1(r_b);
            n_a   = r_a << 1;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == MUL_CNT_W'(MUL_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_a <= n_a;
        r_b <= n_b;
        r_p <= n_p;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_p;

endmodule

`default_nettype wire
